// ----- sv/ccs_pkg.sv -----
// shared types and constants of the cut cycle sequencer
// used by ccs_queue, cut_cycle_sequencer and ccs_checker; no dependencies
package ccs_pkg;

  // queue sizing default
  localparam int QUEUE_DEPTH = 16;

  // motion constants
  localparam int ROT_SCALE     = 128;
  localparam int ROT_SHIFT     = $clog2(ROT_SCALE);
  localparam int STEPS_PER_REV = 200;
  localparam int VERT_REVS     = 6;
  localparam int RETURN_UNITS  = 50;
  localparam int AMOUNT_GAIN   = 2;

  // field widths
  localparam int AMT_W   = 8;
  localparam int STEPS_W = 20;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 2;

  localparam logic [STEPS_W-1:0] VERT_TRAVEL_RST =
    STEPS_W'(VERT_REVS * STEPS_PER_REV * ROT_SCALE);
  localparam logic [STEPS_W-1:0] RETURN_TRAVEL_RST =
    STEPS_W'(RETURN_UNITS * ROT_SCALE);

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_VERTICAL = 2'd0;
  localparam logic [CFG_W-1:0] CFG_RETURN   = 2'd1;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_AMOUNT = 2'd0,
    KIND_START  = 2'd1,
    KIND_TICK   = 2'd2
  } ccs_kind_t;

  // cycle phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ROTATE = 3'd1,
    PH_DOWN   = 3'd2,
    PH_UP     = 3'd3,
    PH_ENDING = 3'd4
  } ccs_phase_t;

  // queue control from sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ccs_qctl_t;

  // queue status to sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } ccs_qstat_t;

endpackage

// ----- sv/cut_cycle_sequencer.sv -----
// top level of the cut cycle sequencer: phase control, counters and results
// depends on ccs_pkg and instantiates ccs_queue
//
// Usage:
//   An item (kind, amount, first_of_packet, motors_busy) is taken at a rising
//   edge with start high and busy low. busy then stays high for one cycle while
//   the item is worked on, and no new item is taken while busy is high.
//   The pace is set by busy, not by the queue memory: the queue's head entry is
//   read at the edge that takes the item and the queue is written as busy falls.
//   A tick that takes a step gives one result: done is high for exactly one
//   cycle, the cycle after the busy one, with the move and counter fields beside
//   it. Other items give no result. The receiver cannot stall, so results are
//   never held back and must be taken as they appear.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Index 0 sets the vertical stroke, index 1 the
//   return rotation; other indexes are ignored. Write only while idle.
//   A synchronous reset (rst high) empties the queue, disarms the cycle,
//   returns to the idle phase and restores the travel registers.
module cut_cycle_sequencer #(
  parameter int QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [ccs_pkg::AMT_W-1:0]     amount,
  input  logic                          first_of_packet,
  input  logic                          motors_busy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccs_pkg::CFG_W-1:0]     cfg_index,
  input  logic [ccs_pkg::STEPS_W-1:0]   cfg_data,
  output logic                          done,
  output logic                          rotate_move,
  output logic                          vertical_move,
  output logic                          direction,
  output logic [ccs_pkg::STEPS_W-1:0]   move_steps,
  output logic [2:0]                    phase,
  output logic [ccs_pkg::CNT_W-1:0]     progress,
  output logic [ccs_pkg::CNT_W-1:0]     total_steps,
  output logic                          still_active,
  output logic                          overflow
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W  = ccs_pkg::CNT_W;

  // configuration
  logic [ccs_pkg::STEPS_W-1:0] vertical_travel;
  logic [ccs_pkg::STEPS_W-1:0] return_travel;

  // sequencer state
  ccs_pkg::ccs_phase_t seq_state, seq_next;
  logic                active, active_next;
  logic [CNT_W-1:0]    amount_count, count_next;
  logic                drop_flag, drop_next;
  logic                exec;

  // captured item
  logic [1:0]                item_kind;
  logic [ccs_pkg::AMT_W-1:0] item_amount;
  logic                      item_first;
  logic                      item_busy;

  // queue link
  ccs_pkg::ccs_qctl_t        qctl;
  ccs_pkg::ccs_qstat_t       qstat;
  logic [ccs_pkg::AMT_W-1:0] q_wr_data;
  logic [ccs_pkg::AMT_W-1:0] q_rd_data;
  logic [FILL_W-1:0]         q_fill;

  // step results
  logic                        step;
  logic                        r_rot, r_vert, r_dir;
  logic [ccs_pkg::STEPS_W-1:0] r_steps;
  logic [CNT_W-1:0]            r_progress, r_total, cut, count_base;
  logic [FILL_W-1:0]           fill_after;
  logic [ccs_pkg::AMT_W-1:0]   pop_amount;

  assign busy      = exec;
  assign cfg_ready = 1'b1;

  ccs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctl    (qctl),
    .wr_data(q_wr_data),
    .rd_data(q_rd_data),
    .fill   (q_fill),
    .stat   (qstat)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_travel <= ccs_pkg::VERT_TRAVEL_RST;
      return_travel   <= ccs_pkg::RETURN_TRAVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ccs_pkg::CFG_VERTICAL) begin
        vertical_travel <= cfg_data;
      end else if (cfg_index == ccs_pkg::CFG_RETURN) begin
        return_travel <= cfg_data;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_kind   <= kind;
      item_amount <= amount;
      item_first  <= first_of_packet;
      item_busy   <= motors_busy;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exec         <= 1'b0;
      seq_state    <= ccs_pkg::PH_IDLE;
      active       <= 1'b0;
      amount_count <= '0;
      drop_flag    <= 1'b0;
    end else begin
      exec         <= start && !busy;
      seq_state    <= seq_next;
      active       <= active_next;
      amount_count <= count_next;
      drop_flag    <= drop_next;
    end
  end

  assign q_wr_data  = ccs_pkg::AMT_W'(item_amount * ccs_pkg::AMOUNT_GAIN);
  assign pop_amount = qstat.empty ? '0 : q_rd_data;
  assign count_base = item_first ? '0 : amount_count;
  assign r_total    = CNT_W'(amount_count * 8'd3 + 8'd1);

  // next state, queue control and step fields
  always_comb begin
    seq_next    = seq_state;
    active_next = active;
    count_next  = amount_count;
    drop_next   = drop_flag;
    qctl        = '0;
    step        = 1'b0;
    r_rot       = 1'b0;
    r_vert      = 1'b0;
    r_dir       = 1'b0;
    r_steps     = '0;
    fill_after  = q_fill;
    if (exec) begin
      case (item_kind)
        ccs_pkg::KIND_AMOUNT: begin
          count_next = count_base;
          if (item_amount != '0) begin
            count_next = count_base + 1'b1;
            if (qstat.full) begin
              drop_next = 1'b1;
            end else begin
              qctl.push = 1'b1;
            end
          end
        end
        ccs_pkg::KIND_START: begin
          if (!active && !item_busy) begin
            active_next = 1'b1;
          end
        end
        ccs_pkg::KIND_TICK: begin
          if (active && !item_busy) begin
            step = 1'b1;
            case (seq_state)
              ccs_pkg::PH_ROTATE: begin
                r_rot    = 1'b1;
                r_dir    = 1'b1;
                r_steps  = ccs_pkg::STEPS_W'(pop_amount) << ccs_pkg::ROT_SHIFT;
                qctl.pop = 1'b1;
                seq_next = ccs_pkg::PH_DOWN;
                if (!qstat.empty) begin
                  fill_after = q_fill - 1'b1;
                end
              end
              ccs_pkg::PH_DOWN: begin
                r_vert   = 1'b1;
                r_steps  = vertical_travel;
                seq_next = ccs_pkg::PH_UP;
              end
              ccs_pkg::PH_UP: begin
                r_vert   = 1'b1;
                r_dir    = 1'b1;
                r_steps  = vertical_travel;
                seq_next = qstat.empty ? ccs_pkg::PH_ENDING : ccs_pkg::PH_ROTATE;
              end
              ccs_pkg::PH_ENDING: begin
                r_rot       = 1'b1;
                r_steps     = return_travel;
                qctl.clear  = 1'b1;
                drop_next   = 1'b0;
                active_next = 1'b0;
                fill_after  = '0;
                seq_next    = ccs_pkg::PH_IDLE;
              end
              default: begin
                seq_next = ccs_pkg::PH_ROTATE;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // progress counter of the step just done
  assign cut = amount_count - CNT_W'(fill_after);
  always_comb begin
    case (seq_state)
      ccs_pkg::PH_ROTATE: r_progress = cut * 8'd3 - 8'd1;
      ccs_pkg::PH_DOWN:   r_progress = cut * 8'd3;
      ccs_pkg::PH_UP:     r_progress = cut * 8'd3 + 8'd1;
      ccs_pkg::PH_ENDING: r_progress = r_total;
      default:            r_progress = 8'd1;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= step;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (step) begin
      rotate_move   <= r_rot;
      vertical_move <= r_vert;
      direction     <= r_dir;
      move_steps    <= r_steps;
      phase         <= (seq_state == ccs_pkg::PH_ROTATE || seq_state == ccs_pkg::PH_DOWN ||
                        seq_state == ccs_pkg::PH_UP || seq_state == ccs_pkg::PH_ENDING)
                       ? seq_state : ccs_pkg::PH_IDLE;
      progress      <= r_progress;
      total_steps   <= r_total;
      still_active  <= active_next;
      overflow      <= drop_next;
    end
  end

endmodule

// ----- sv/ccs_queue.sv -----
// amount queue: synchronous memory with head, tail and fill registers
// depends on ccs_pkg for the control and status structs
module ccs_queue #(
  parameter int DEPTH = ccs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ccs_pkg::ccs_qctl_t         ctl,
  input  logic [ccs_pkg::AMT_W-1:0]  wr_data,
  output logic [ccs_pkg::AMT_W-1:0]  rd_data,
  output logic [$clog2(DEPTH+1)-1:0] fill,
  output ccs_pkg::ccs_qstat_t        stat
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [ccs_pkg::AMT_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]          head;
  logic [PTR_W-1:0]          tail;
  logic                      do_push;
  logic                      do_pop;

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FILL_W'(DEPTH));
  assign do_push    = ctl.push && !stat.full;
  assign do_pop     = ctl.pop && !stat.empty;

  // storage, read port follows the head
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wr_data;
    end
    rd_data <= mem[head];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
        fill <= fill + 1'b1;
      end else if (do_pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ccs_checker.sv -----
// port-level checks of the cut cycle sequencer, bound to the top level
// depends on ccs_pkg and cut_cycle_sequencer
module ccs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic                          rotate_move,
  input logic                          vertical_move,
  input logic                          still_active,
  input logic [ccs_pkg::STEPS_W-1:0]   move_steps,
  input logic [2:0]                    phase,
  input logic [ccs_pkg::CNT_W-1:0]     progress,
  input logic [ccs_pkg::CNT_W-1:0]     total_steps
);

  // a taken item holds the block busy for the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an item was taken");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe outside its slot");

  // ending step closes the cycle with progress at total
  a_ending: assert property (@(posedge clk) disable iff (rst)
    done && phase == ccs_pkg::PH_ENDING |-> !still_active && progress == total_steps)
    else $error("ending step did not close the cycle");

  // idle step issues no move
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    done && phase == ccs_pkg::PH_IDLE |->
      !rotate_move && !vertical_move && move_steps == '0 && still_active)
    else $error("idle step issued a move");

endmodule

bind cut_cycle_sequencer ccs_checker u_ccs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .rotate_move  (rotate_move),
  .vertical_move(vertical_move),
  .still_active (still_active),
  .move_steps   (move_steps),
  .phase        (phase),
  .progress     (progress),
  .total_steps  (total_steps)
);
